// ===== sv/a2y_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2y_pkg
// Shared widths, register indexes and color coefficients for the ARGB to
// YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package a2y_pkg;

	// configuration port
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	// pixel and result widths
	localparam int PIX_W  = 32;
	localparam int CH_W   = 8;
	// numerators stay in 0..25550
	localparam int NUM_W  = 15;

	// bt.601 style coefficients, scaled by 100
	localparam int unsigned Y_R    = 30;
	localparam int unsigned Y_G    = 59;
	localparam int unsigned Y_B    = 11;
	localparam int unsigned U_R    = 17;
	localparam int unsigned U_G    = 33;
	localparam int unsigned U_B    = 50;
	localparam int unsigned V_R    = 50;
	localparam int unsigned V_G    = 42;
	localparam int unsigned V_B    = 8;
	localparam int unsigned C_BIAS = 12800;

	// divide by 100 as multiply by 5243 and shift by 19, exact below 43690
	localparam int MUL_W        = 13;
	localparam int unsigned DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;
	localparam int PROD_W       = NUM_W + MUL_W;

	typedef logic [NUM_W-1:0] num_t;

	// quotient of a numerator by 100
	function automatic logic [CH_W-1:0] div100(input num_t n);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(n) * PROD_W'(DIV100_MUL);
		return prod[DIV100_SHIFT +: CH_W];
	endfunction

endpackage

// ===== sv/argb_to_yuv420_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_to_yuv420_converter
// Converts a raster stream of ARGB pixels to Y on every pixel and U/V on
// pixels at even column and even row (top-left 2x2 subsampling). One pixel
// is taken per clock unless the pipe is stalled: stage one registers the
// three weighted sums, stage two divides each by 100 with a constant
// multiply into the result register, which drives the output. The input
// stalls only while both stages hold beats and out_ready is low. Column
// and row counters track the raster position and wrap at the end of the
// frame, which is flagged on the last pixel. A frame side of 0 acts as 1,
// and one above MAX_FRAME_SIDE acts as MAX_FRAME_SIDE. Alpha is ignored,
// and U/V read 0 when chroma_valid is low.
// ----------------------------------------------------------------------------
module argb_to_yuv420_converter #(
	parameter int MAX_FRAME_SIDE = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [a2y_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [a2y_pkg::CFG_W-1:0]         cfg_data,
	// pixel input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [a2y_pkg::PIX_W-1:0]         pixel_argb,
	// result output
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [a2y_pkg::CH_W-1:0]          luma,
	output logic [a2y_pkg::CH_W-1:0]          chroma_u,
	output logic [a2y_pkg::CH_W-1:0]          chroma_v,
	output logic                              chroma_valid,
	output logic                              end_of_frame
);

	localparam int CW = $clog2(MAX_FRAME_SIDE);
	localparam int SW = (CW + 1 > a2y_pkg::CFG_W) ? CW + 1 : a2y_pkg::CFG_W;
	localparam int NW = a2y_pkg::NUM_W;

	// configuration registers
	logic [a2y_pkg::CFG_W-1:0] frame_width_q, frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= a2y_pkg::CFG_W'(640);
			frame_height_q <= a2y_pkg::CFG_W'(480);
		end else if (cfg_we) begin
			case (cfg_index)
				a2y_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				a2y_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective frame limits (side minus one)
	logic [SW-1:0] w_ext, h_ext, w_eff, h_eff, w_lim, h_lim;

	always_comb begin
		w_ext = SW'(frame_width_q);
		h_ext = SW'(frame_height_q);
		if (w_ext == '0)
			w_eff = SW'(1);
		else if (w_ext > SW'(MAX_FRAME_SIDE))
			w_eff = SW'(MAX_FRAME_SIDE);
		else
			w_eff = w_ext;
		if (h_ext == '0)
			h_eff = SW'(1);
		else if (h_ext > SW'(MAX_FRAME_SIDE))
			h_eff = SW'(MAX_FRAME_SIDE);
		else
			h_eff = h_ext;
		w_lim = w_eff - SW'(1);
		h_lim = h_eff - SW'(1);
	end

	// pipeline flow control
	logic vld_s1, vld_s2;
	logic adv_s1, adv_s2, in_beat;

	assign adv_s2   = !vld_s2 || out_ready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign in_beat  = in_valid && in_ready;

	// raster position
	logic [CW-1:0] col_q, row_q;
	logic          last_col, last_row, chroma_pos;

	assign last_col   = SW'(col_q) >= w_lim;
	assign last_row   = SW'(row_q) >= h_lim;
	assign chroma_pos = !col_q[0] && !row_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_beat) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row)
					row_q <= '0;
				else
					row_q <= row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// weighted sums, modulo arithmetic is exact since each lies in 0..25550
	logic [NW-1:0] r_n, g_n, b_n, y_num, u_num, v_num;

	always_comb begin
		r_n   = NW'(pixel_argb[23:16]);
		g_n   = NW'(pixel_argb[15:8]);
		b_n   = NW'(pixel_argb[7:0]);
		y_num = NW'(a2y_pkg::Y_R) * r_n + NW'(a2y_pkg::Y_G) * g_n
			+ NW'(a2y_pkg::Y_B) * b_n;
		u_num = NW'(a2y_pkg::U_B) * b_n + NW'(a2y_pkg::C_BIAS)
			- NW'(a2y_pkg::U_R) * r_n - NW'(a2y_pkg::U_G) * g_n;
		v_num = NW'(a2y_pkg::V_R) * r_n + NW'(a2y_pkg::C_BIAS)
			- NW'(a2y_pkg::V_G) * g_n - NW'(a2y_pkg::V_B) * b_n;
	end

	// stage one: numerators and position flags
	a2y_pkg::num_t y_num_s1, u_num_s1, v_num_s1;
	logic          chroma_s1, eof_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv_s1)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			y_num_s1  <= y_num;
			u_num_s1  <= chroma_pos ? u_num : '0;
			v_num_s1  <= chroma_pos ? v_num : '0;
			chroma_s1 <= chroma_pos;
			eof_s1    <= last_col && last_row;
		end
	end

	// stage two: divide by 100 and hold the result beat
	logic [a2y_pkg::CH_W-1:0] luma_s2, u_s2, v_s2;
	logic                     chroma_s2, eof_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv_s2)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			luma_s2   <= a2y_pkg::div100(y_num_s1);
			u_s2      <= a2y_pkg::div100(u_num_s1);
			v_s2      <= a2y_pkg::div100(v_num_s1);
			chroma_s2 <= chroma_s1;
			eof_s2    <= eof_s1;
		end
	end

	assign out_valid    = vld_s2;
	assign luma         = luma_s2;
	assign chroma_u     = u_s2;
	assign chroma_v     = v_s2;
	assign chroma_valid = chroma_s2;
	assign end_of_frame = eof_s2;

endmodule

// ===== sv/a2y_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2y_checker
// Port level checks for the ARGB to YUV 4:2:0 converter, bound to the top.
// ----------------------------------------------------------------------------
module a2y_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [a2y_pkg::CH_W-1:0]      luma,
	input logic [a2y_pkg::CH_W-1:0]      chroma_u,
	input logic [a2y_pkg::CH_W-1:0]      chroma_v,
	input logic                          chroma_valid,
	input logic                          end_of_frame
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(luma) && $stable(chroma_u)
			&& $stable(chroma_v) && $stable(chroma_valid) && $stable(end_of_frame))
		else $error("result beat changed while stalled");

	// unused chroma reads zero
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chroma_valid |-> chroma_u == '0 && chroma_v == '0)
		else $error("chroma not zero on a luma-only beat");

	// a draining output never blocks the input
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// a pixel accepted into an empty pipe reaches the output through stage one and stage two
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> ##1 out_valid)
		else $error("accepted pixel did not reach the output");

endmodule

bind argb_to_yuv420_converter a2y_checker u_a2y_checker (.*);
